@@ hw/rtl/raa_pkg.sv @@
// Shared types, codes and reset values for the RC / autonomy arming arbiter.
`default_nettype none

package raa_pkg;

	localparam int unsigned AGE_W    = 16;
	localparam int unsigned GAP_W    = 8;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned WDOG_W   = 8;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [AGE_W-1:0]   AGE_MAX = '1;
	localparam logic [GAP_W-1:0]   GAP_MAX = '1;

	localparam logic [AGE_W-1:0]   RST_RC_TIMEOUT  = 16'd100;
	localparam logic [AGE_W-1:0]   RST_CMD_TIMEOUT = 16'd500;
	localparam logic [GAP_W-1:0]   RST_MIN_GAP     = 8'd6;
	localparam logic [COUNT_W-1:0] RST_ARM_REPEATS = 4'd5;
	localparam logic [WDOG_W-1:0]  RST_WDOG_PERIOD = 8'd9;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_ARMING = 2'd1,
		MODE_AUTO   = 2'd2,
		MODE_RC     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_OFF  = 2'd1,
		SRC_RC   = 2'd2,
		SRC_CMD  = 2'd3
	} src_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK    = 3'd0,
		KIND_RC      = 3'd1,
		KIND_COMMAND = 3'd2,
		KIND_ARM     = 3'd3,
		KIND_DISARM  = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RC_TIMEOUT  = 3'd0,
		CFG_CMD_TIMEOUT = 3'd1,
		CFG_MIN_GAP     = 3'd2,
		CFG_ARM_REPEATS = 3'd3,
		CFG_WDOG_PERIOD = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [AGE_W-1:0]   rc_timeout_ticks;
		logic [AGE_W-1:0]   command_timeout_ticks;
		logic [GAP_W-1:0]   min_send_gap_ticks;
		logic [COUNT_W-1:0] arming_repeats;
		logic [WDOG_W-1:0]  watchdog_period_ticks;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              rc_armed;
		logic              motors_enabled;
	} item_t;

	typedef struct packed {
		logic  frame_sent;
		src_t  frame_source;
		logic  arm_flag;
		logic  force_min_throttle;
		mode_t mode;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/raa_channels.sv @@
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface raa_item_if;
	logic                       valid;
	logic                       ready;
	logic [raa_pkg::KIND_W-1:0] kind;
	logic                       rc_armed;
	logic                       motors_enabled;

	modport source (output valid, kind, rc_armed, motors_enabled, input ready);
	modport sink   (input valid, kind, rc_armed, motors_enabled, output ready);
endinterface

interface raa_result_if;
	logic       valid;
	logic       ready;
	logic       frame_sent;
	logic [1:0] frame_source;
	logic       arm_flag;
	logic       force_min_throttle;
	logic [1:0] mode;

	modport source (output valid, frame_sent, frame_source, arm_flag, force_min_throttle,
		mode, input ready);
	modport sink   (input valid, frame_sent, frame_source, arm_flag, force_min_throttle,
		mode, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/raa_cfg.sv @@
// Configuration register file written through the plain write port.
`default_nettype none

module raa_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [raa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [raa_pkg::CFG_DATA_W-1:0] cfg_data,
	output raa_pkg::cfg_t                       cfg
);
	import raa_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rc_timeout_ticks      <= RST_RC_TIMEOUT;
			cfg_q.command_timeout_ticks <= RST_CMD_TIMEOUT;
			cfg_q.min_send_gap_ticks    <= RST_MIN_GAP;
			cfg_q.arming_repeats        <= RST_ARM_REPEATS;
			cfg_q.watchdog_period_ticks <= RST_WDOG_PERIOD;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_RC_TIMEOUT:  cfg_q.rc_timeout_ticks      <= cfg_data[AGE_W-1:0];
				CFG_CMD_TIMEOUT: cfg_q.command_timeout_ticks <= cfg_data[AGE_W-1:0];
				CFG_MIN_GAP:     cfg_q.min_send_gap_ticks    <= cfg_data[GAP_W-1:0];
				CFG_ARM_REPEATS: cfg_q.arming_repeats        <= cfg_data[COUNT_W-1:0];
				CFG_WDOG_PERIOD: cfg_q.watchdog_period_ticks <= cfg_data[WDOG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/raa_core.sv @@
// Arbiter state and the single-pass mode, age and send-gap update for one item.
`default_nettype none

module raa_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  raa_pkg::item_t item,
	input  raa_pkg::cfg_t  cfg,
	output raa_pkg::result_t res
);
	import raa_pkg::*;

	mode_t              mode_q, mode_n;
	logic               enabled_q, enabled_n;
	logic               seen_q, seen_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic [AGE_W-1:0]   rc_age_q, rc_age_n;
	logic [AGE_W-1:0]   cmd_age_q, cmd_age_n;
	logic [GAP_W-1:0]   since_q, since_n;
	logic [WDOG_W-1:0]  wdog_q, wdog_n;

	logic snd_req;
	src_t snd_src;
	logic snd_arm;
	logic snd_force;
	logic snd_inc;

	always_comb begin
		mode_n    = mode_q;
		enabled_n = enabled_q;
		seen_n    = seen_q;
		count_n   = count_q;
		rc_age_n  = rc_age_q;
		cmd_age_n = cmd_age_q;
		since_n   = since_q;
		wdog_n    = wdog_q;
		snd_req   = 1'b0;
		snd_src   = SRC_NONE;
		snd_arm   = 1'b0;
		snd_force = 1'b0;
		snd_inc   = 1'b0;
		res       = '0;

		case (item.kind)
			KIND_TICK: begin
				if (rc_age_q != AGE_MAX) rc_age_n = rc_age_q + 1'b1;
				if (cmd_age_q != AGE_MAX) cmd_age_n = cmd_age_q + 1'b1;
				if (since_q != GAP_MAX) since_n = since_q + 1'b1;
				wdog_n = wdog_q + 1'b1;
				if (wdog_n >= cfg.watchdog_period_ticks) begin
					wdog_n = '0;
					if (mode_n == MODE_RC && rc_age_n > cfg.rc_timeout_ticks)
						mode_n = MODE_AUTO;
					if ((mode_n == MODE_ARMING || mode_n == MODE_AUTO) &&
							cmd_age_n > cfg.command_timeout_ticks)
						mode_n = MODE_OFF;
					if (mode_n == MODE_OFF) begin
						snd_req = 1'b1;
						snd_src = SRC_OFF;
					end
				end
			end
			KIND_RC: begin
				rc_age_n = '0;
				if (item.rc_armed) begin
					// An armed frame counts only once a disarmed frame has been seen.
					if (seen_q) begin
						mode_n  = MODE_RC;
						snd_req = 1'b1;
						snd_src = SRC_RC;
						snd_arm = 1'b1;
					end
				end else if (mode_q == MODE_RC) begin
					mode_n = enabled_q ? MODE_AUTO : MODE_OFF;
				end else begin
					seen_n = 1'b1;
				end
			end
			KIND_COMMAND: begin
				if (enabled_q && mode_q != MODE_RC) begin
					snd_req = 1'b1;
					snd_src = SRC_CMD;
					snd_arm = item.motors_enabled;
					if (item.motors_enabled) begin
						cmd_age_n = '0;
						if (mode_q == MODE_OFF) begin
							mode_n  = MODE_ARMING;
							count_n = '0;
						end
					end else begin
						mode_n = MODE_OFF;
					end
				end
			end
			KIND_ARM:    enabled_n = 1'b1;
			KIND_DISARM: enabled_n = 1'b0;
			default: ;
		endcase

		// The updated mode shapes the candidate frame before the send-gap check.
		if (snd_req) begin
			case (mode_n)
				MODE_OFF:  snd_arm = 1'b0;
				MODE_ARMING: begin
					if (count_n >= cfg.arming_repeats) begin
						mode_n = MODE_AUTO;
					end else begin
						snd_force = 1'b1;
						snd_arm   = 1'b1;
						snd_inc   = 1'b1;
					end
				end
				MODE_AUTO: snd_arm = 1'b1;
				default: ;
			endcase
			// A suppressed frame leaves the arming count where it was.
			if (since_n > cfg.min_send_gap_ticks) begin
				since_n                = '0;
				res.frame_sent         = 1'b1;
				res.frame_source       = snd_src;
				res.arm_flag           = snd_arm;
				res.force_min_throttle = snd_force;
				if (snd_inc) count_n = count_n + 1'b1;
			end
		end
		res.mode = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_OFF;
			enabled_q <= 1'b0;
			seen_q    <= 1'b0;
			count_q   <= '0;
			rc_age_q  <= AGE_MAX;
			cmd_age_q <= AGE_MAX;
			since_q   <= GAP_MAX;
			wdog_q    <= '0;
		end else if (fire) begin
			mode_q    <= mode_n;
			enabled_q <= enabled_n;
			seen_q    <= seen_n;
			count_q   <= count_n;
			rc_age_q  <= rc_age_n;
			cmd_age_q <= cmd_age_n;
			since_q   <= since_n;
			wdog_q    <= wdog_n;
		end
	end

	a_force_only_arming: assert property (@(posedge clk) disable iff (!arst_n)
		res.force_min_throttle |-> (res.frame_sent && res.arm_flag && mode_n == MODE_ARMING))
		else $error("forced minimum throttle outside arming");

	a_rc_sent_rc_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.frame_sent && res.frame_source == SRC_RC) |=> (mode_q == MODE_RC))
		else $error("RC frame sent but mode is not RC flight");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> ($stable(mode_q) && $stable(count_q) && $stable(since_q)))
		else $error("arbiter state changed without an item");

	a_sent_resets_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.frame_sent) |=> (since_q == '0))
		else $error("send-gap counter not restarted after a sent frame");

endmodule

`default_nettype wire

@@ hw/rtl/rc_autonomy_arming_arbiter.sv @@
// Top level of the RC / autonomy arming arbiter: input stage, core and result register.
//
//  channel   dir  transfer on          payload
//  item      in   valid && ready       kind, rc_armed, motors_enabled
//  result    out  valid && ready       frame_sent, frame_source, arm_flag,
//                                      force_min_throttle, mode
//  cfg       in   cfg_write            cfg_index, cfg_data
//
// Each item passes through the input register and then the result register, so its result
// is valid once the core has fired on it and registered it in the result register; one item
// per cycle is sustained while the result side is ready.
// The rate is set by the single combinational update of the arbiter state in the core.
// Reset clears the mode, interlock and counters, sets the ages and send gap to their maximum
// and loads the register defaults. A stalled result holds the input stage, which then holds ready low until it drains.
`default_nettype none

module rc_autonomy_arming_arbiter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	raa_item_if.sink                            item,
	raa_result_if.source                        result,
	input  wire logic                           cfg_write,
	input  wire logic [raa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [raa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import raa_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_c;
	result_t res_s2;
	logic    valid_s2;
	logic    fire;

	raa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign fire       = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.kind           <= item.kind;
			item_s1.rc_armed       <= item.rc_armed;
			item_s1.motors_enabled <= item.motors_enabled;
		end
	end

	raa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) res_s2 <= res_c;
	end

	assign result.valid              = valid_s2;
	assign result.frame_sent         = res_s2.frame_sent;
	assign result.frame_source       = res_s2.frame_source;
	assign result.arm_flag           = res_s2.arm_flag;
	assign result.force_min_throttle = res_s2.force_min_throttle;
	assign result.mode               = res_s2.mode;

	a_stage_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !result.ready) |=> valid_s1)
		else $error("input stage lost an item while the result was stalled");

endmodule

`default_nettype wire

@@ tb/rc_autonomy_arming_arbiter_test.sv @@
// Self-checking testbench for the RC / autonomy arming arbiter with its own mode predictor.
`default_nettype none

module rc_autonomy_arming_arbiter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import raa_pkg::*;

	localparam int unsigned KIND_SPAN = 1 << KIND_W;

	// Keeps its own copy of the arbiter state and the queue of results still to arrive.
	class arming_scoreboard;
		cfg_t    regs;
		mode_t   fsm_mode;
		bit      bridge_armed;
		bit      rc_disarm_seen;
		logic [COUNT_W-1:0] arm_count;
		logic [AGE_W-1:0]   rc_age;
		logic [AGE_W-1:0]   cmd_age;
		logic [GAP_W-1:0]   send_gap_age;
		logic [WDOG_W-1:0]  wdog_div;
		result_t frame;
		result_t pending_results[$];
		int mismatches;
		int items_seen;
		int results_checked;
		int frames_sent;
		int forced_frames;
		int mode_hits[4];

		function new();
			regs.rc_timeout_ticks      = RST_RC_TIMEOUT;
			regs.command_timeout_ticks = RST_CMD_TIMEOUT;
			regs.min_send_gap_ticks    = RST_MIN_GAP;
			regs.arming_repeats        = RST_ARM_REPEATS;
			regs.watchdog_period_ticks = RST_WDOG_PERIOD;
			fsm_mode       = MODE_OFF;
			bridge_armed   = 1'b0;
			rc_disarm_seen = 1'b0;
			arm_count      = '0;
			rc_age         = AGE_MAX;
			cmd_age        = AGE_MAX;
			send_gap_age   = GAP_MAX;
			wdog_div       = '0;
		endfunction

		function void enter(mode_t m);
			fsm_mode = m;
			if (m == MODE_ARMING) begin
				arm_count = '0;
			end
		endfunction

		// The mode shapes the candidate frame, then the send-gap limit may drop it.
		function void offer_frame(src_t src, logic arm);
			logic force_min;
			force_min = 1'b0;
			case (fsm_mode)
				MODE_OFF: begin
					arm = 1'b0;
				end
				MODE_ARMING: begin
					if (arm_count >= regs.arming_repeats) begin
						enter(MODE_AUTO);
					end else begin
						force_min = 1'b1;
						arm = 1'b1;
						arm_count = arm_count + 1'b1;
					end
				end
				MODE_AUTO: begin
					arm = 1'b1;
				end
				default: ;
			endcase
			if (send_gap_age <= regs.min_send_gap_ticks) begin
				// A suppressed arming frame does not count towards the repeats.
				if (fsm_mode == MODE_ARMING) begin
					arm_count = arm_count - 1'b1;
				end
				return;
			end
			send_gap_age             = '0;
			frame.frame_sent         = 1'b1;
			frame.frame_source       = src;
			frame.arm_flag           = arm;
			frame.force_min_throttle = force_min;
		endfunction

		function void tick();
			if (rc_age != AGE_MAX) rc_age = rc_age + 1'b1;
			if (cmd_age != AGE_MAX) cmd_age = cmd_age + 1'b1;
			if (send_gap_age != GAP_MAX) send_gap_age = send_gap_age + 1'b1;
			wdog_div = wdog_div + 1'b1;
			if (wdog_div < regs.watchdog_period_ticks) begin
				return;
			end
			wdog_div = '0;
			if (fsm_mode == MODE_RC && rc_age > regs.rc_timeout_ticks) begin
				enter(MODE_AUTO);
			end
			if ((fsm_mode == MODE_ARMING || fsm_mode == MODE_AUTO) &&
				cmd_age > regs.command_timeout_ticks) begin
				enter(MODE_OFF);
			end
			if (fsm_mode == MODE_OFF) begin
				offer_frame(SRC_OFF, 1'b0);
			end
		endfunction

		function void rc_frame(logic armed);
			rc_age = '0;
			if (armed) begin
				// An armed stick is ignored until a disarmed one has been seen.
				if (!rc_disarm_seen) begin
					return;
				end
				if (fsm_mode != MODE_RC) begin
					enter(MODE_RC);
				end
				offer_frame(SRC_RC, 1'b1);
			end else if (fsm_mode == MODE_RC) begin
				enter(bridge_armed ? MODE_AUTO : MODE_OFF);
			end else begin
				rc_disarm_seen = 1'b1;
			end
		endfunction

		function void command(logic active);
			if (!bridge_armed || fsm_mode == MODE_RC) begin
				return;
			end
			if (active) begin
				cmd_age = '0;
				if (fsm_mode == MODE_OFF) begin
					enter(MODE_ARMING);
				end
				offer_frame(SRC_CMD, 1'b1);
			end else begin
				if (fsm_mode == MODE_ARMING || fsm_mode == MODE_AUTO) begin
					enter(MODE_OFF);
				end
				offer_frame(SRC_CMD, 1'b0);
			end
		endfunction

		function void note_item(item_t it);
			frame = '0;
			case (it.kind)
				KIND_TICK:    tick();
				KIND_RC:      rc_frame(it.rc_armed);
				KIND_COMMAND: command(it.motors_enabled);
				KIND_ARM:     bridge_armed = 1'b1;
				KIND_DISARM:  bridge_armed = 1'b0;
				default: ;
			endcase
			frame.mode = fsm_mode;
			items_seen++;
			mode_hits[fsm_mode]++;
			if (frame.frame_sent) frames_sent++;
			if (frame.force_min_throttle) forced_frames++;
			pending_results.push_back(frame);
		endfunction

		task report(string what, logic [3:0] got, logic [3:0] want);
			$display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report("result with nothing outstanding", 4'(got.mode), 4'h0);
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			if (got.frame_sent !== want.frame_sent)
				report("frame_sent", 4'(got.frame_sent), 4'(want.frame_sent));
			if (got.frame_source !== want.frame_source)
				report("frame_source", 4'(got.frame_source), 4'(want.frame_source));
			if (got.arm_flag !== want.arm_flag)
				report("arm_flag", 4'(got.arm_flag), 4'(want.arm_flag));
			if (got.force_min_throttle !== want.force_min_throttle)
				report("force_min_throttle", 4'(got.force_min_throttle),
					4'(want.force_min_throttle));
			if (got.mode !== want.mode)
				report("mode", 4'(got.mode), 4'(want.mode));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit idling_on;
	int settings_run;

	raa_item_if   item_ch ();
	raa_result_if result_ch ();

	arming_scoreboard sb;

	rc_autonomy_arming_arbiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) begin
			sb.note_item({item_ch.kind, item_ch.rc_armed, item_ch.motors_enabled});
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			sb.check_result({result_ch.frame_sent, result_ch.frame_source, result_ch.arm_flag,
				result_ch.force_min_throttle, result_ch.mode});
		end
	end

	// Result side back-pressure in random bursts while idling is on.
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (idling_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	task automatic push_item(logic [KIND_W-1:0] kind, logic rc_armed, logic motors);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.kind           <= kind;
		item_ch.rc_armed       <= rc_armed;
		item_ch.motors_enabled <= motors;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic load_config(cfg_t c);
		write_reg(CFG_RC_TIMEOUT, c.rc_timeout_ticks);
		write_reg(CFG_CMD_TIMEOUT, c.command_timeout_ticks);
		write_reg(CFG_MIN_GAP, CFG_DATA_W'(c.min_send_gap_ticks));
		write_reg(CFG_ARM_REPEATS, CFG_DATA_W'(c.arming_repeats));
		write_reg(CFG_WDOG_PERIOD, CFG_DATA_W'(c.watchdog_period_ticks));
		cfg_write <= 1'b0;
		sb.regs = c;
		settings_run++;
	endtask

	// Lower valid after the last transfer and let every outstanding result come back.
	// The first edge makes sure the last transfer has reached the scoreboard.
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly flight-like traffic: ticks, active commands and RC frames, with some noise.
	task automatic run_mix(int count);
		int done;
		int r;
		int burst;
		logic rc_bit;
		logic mot_bit;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			rc_bit = 1'($urandom_range(0, 1));
			mot_bit = 1'($urandom_range(0, 1));
			if (r < 42) begin
				push_item(KIND_TICK, rc_bit, mot_bit);
				done++;
			end else if (r < 66) begin
				push_item(KIND_COMMAND, rc_bit, $urandom_range(0, 6) != 0);
				done++;
			end else if (r < 80) begin
				push_item(KIND_RC, rc_bit, mot_bit);
				done++;
			end else if (r < 87) begin
				push_item(KIND_ARM, rc_bit, mot_bit);
				done++;
			end else if (r < 91) begin
				push_item(KIND_DISARM, rc_bit, mot_bit);
				done++;
			end else if (r < 95) begin
				push_item(KIND_W'($urandom_range(int'(KIND_DISARM) + 1, KIND_SPAN - 1)),
					rc_bit, mot_bit);
			end else begin
				// A run of up to 12 ticks, which can clear a small send gap.
				burst = $urandom_range(1, 12);
				repeat (burst) begin
					push_item(KIND_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					done++;
				end
			end
		end
	endtask

	task automatic run_phase(cfg_t c, int count, bit idle);
		idling_on = idle;
		load_config(c);
		run_mix(count);
		drain();
	endtask

	function automatic cfg_t random_small_cfg();
		cfg_t c;
		c.rc_timeout_ticks      = AGE_W'($urandom_range(0, 50));
		c.command_timeout_ticks = AGE_W'($urandom_range(0, 150));
		c.min_send_gap_ticks    = GAP_W'($urandom_range(0, 5));
		c.arming_repeats        = COUNT_W'($urandom_range(1, 15));
		c.watchdog_period_ticks = WDOG_W'($urandom_range(1, 12));
		return c;
	endfunction

	initial begin
		cfg_t c;
		sb = new();
		settings_run = 0;
		idling_on = 1'b1;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.kind <= KIND_TICK;
		item_ch.rc_armed <= 1'b0;
		item_ch.motors_enabled <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through the reset settings.
		for (int k = int'(KIND_DISARM) + 1; k < KIND_SPAN; k++) begin
			push_item(KIND_W'(k), 1'b1, 1'b1);
		end
		push_item(KIND_RC, 1'b1, 1'b0);
		push_item(KIND_COMMAND, 1'b0, 1'b1);
		push_item(KIND_RC, 1'b0, 1'b1);
		push_item(KIND_ARM, 1'b0, 1'b0);
		push_item(KIND_COMMAND, 1'b0, 1'b1);
		push_item(KIND_COMMAND, 1'b0, 1'b1);
		repeat (9) push_item(KIND_TICK, 1'b0, 1'b0);
		push_item(KIND_COMMAND, 1'b1, 1'b1);
		push_item(KIND_COMMAND, 1'b1, 1'b0);
		push_item(KIND_RC, 1'b1, 1'b0);
		push_item(KIND_RC, 1'b0, 1'b0);
		push_item(KIND_DISARM, 1'b1, 1'b1);
		push_item(KIND_COMMAND, 1'b0, 1'b1);
		drain();

		c = '{rc_timeout_ticks: 20, command_timeout_ticks: 60, min_send_gap_ticks: 2,
			arming_repeats: 3, watchdog_period_ticks: 4};
		run_phase(c, 230, 1'b1);
		c = '0;
		run_phase(c, 200, 1'b1);
		c = '{rc_timeout_ticks: AGE_MAX, command_timeout_ticks: AGE_MAX,
			min_send_gap_ticks: GAP_MAX, arming_repeats: '1, watchdog_period_ticks: '1};
		run_phase(c, 120, 1'b1);
		run_phase(random_small_cfg(), 250, 1'b1);
		c = '{rc_timeout_ticks: AGE_MAX, command_timeout_ticks: AGE_MAX, min_send_gap_ticks: 0,
			arming_repeats: '1, watchdog_period_ticks: 1};
		run_phase(c, 200, 1'b1);
		c = '{rc_timeout_ticks: 1, command_timeout_ticks: 1, min_send_gap_ticks: 1,
			arming_repeats: 1, watchdog_period_ticks: '1};
		run_phase(c, 150, 1'b1);
		// The final part runs with no idling on either side.
		run_phase(random_small_cfg(), 250, 1'b0);
		run_phase(random_small_cfg(), 250, 1'b0);

		$display("Run covered %0d items under %0d register settings; %0d results checked.",
			sb.items_seen, settings_run, sb.results_checked);
		$display("Frames sent %0d (%0d at minimum throttle); %s %0d, %s %0d, %s %0d, %s %0d.",
			sb.frames_sent, sb.forced_frames, "modes seen off", sb.mode_hits[MODE_OFF],
			"arming", sb.mode_hits[MODE_ARMING], "autonomous", sb.mode_hits[MODE_AUTO],
			"RC", sb.mode_hits[MODE_RC]);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("** rc_autonomy_arming_arbiter: PASSED **");
		end else begin
			$display("** rc_autonomy_arming_arbiter: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding.", sb.pending_results.size());
		$display("** rc_autonomy_arming_arbiter: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
